### sv/hdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_pkg - shared types and constants
// Configuration register map, queue entry layout and default parameters for
// the horizontal delta predictor.
// ----------------------------------------------------------------------------
package hdp_pkg;

    localparam int MAX_CHANNELS_DEF = 3;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int BYTE_W     = 8;
    localparam int SPP_W      = 2;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] SIGN8 = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDE_SAMPLES = 2'd0,
        CFG_SAMPLES_PER_PIXEL = 2'd1,
        CFG_ROW_WIDTH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             wide;
        logic [SPP_W-1:0] spp;
        logic [ROW_W-1:0] row;
    } t_cfg;

    // one finished sample: one byte (narrow) or two bytes (wide)
    typedef struct packed {
        logic              wide;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
    } t_qent;

endpackage

### sv/hdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_front - byte intake and prediction
// Assembles samples from bytes, subtracts the same channel's previous sample
// except at a row start, flips the sign bit and pushes finished samples into the queue.
// ----------------------------------------------------------------------------
module hdp_front #(
    parameter int MAX_CHANNELS = hdp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = hdp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hdp_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [hdp_pkg::BYTE_W-1:0]  i_data,
    output logic                        o_ready,
    input  logic                        i_q_ready,
    output logic                        o_q_push,
    output hdp_pkg::t_qent              o_q_entry
);

    localparam logic [SAMPLE_BITS-1:0] SIGN_W = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic [SAMPLE_BITS-1:0]          r_prev [MAX_CHANNELS];
    logic [1:0]                      r_chan;
    logic [hdp_pkg::ROW_W-1:0]       r_col;
    logic [hdp_pkg::BYTE_W-1:0]      r_held;
    logic                            r_phase;

    logic [1:0]                      n_chan;
    logic [hdp_pkg::ROW_W-1:0]       n_col;

    logic                            accept;
    logic                            step;
    logic [2:0]                      ch_ext;
    logic [2:0]                      ch_sel;
    logic [2:0]                      spp_eff;
    logic [hdp_pkg::ROW_W-1:0]       row_eff;
    logic [SAMPLE_BITS-1:0]          prev;
    logic [SAMPLE_BITS-1:0]          sample;
    logic [SAMPLE_BITS-1:0]          res_w;
    logic [hdp_pkg::BYTE_W-1:0]      res_n;
    logic [15:0]                     res_w16;
    logic [1:0]                      chan_inc;
    logic [hdp_pkg::ROW_W-1:0]       col_inc;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;
    // a sample is complete on every narrow byte and on the high byte of a wide one
    assign step    = accept && (!i_cfg.wide || r_phase);

    assign ch_ext = {1'b0, r_chan};
    assign ch_sel = (ch_ext < 3'(MAX_CHANNELS)) ? ch_ext : 3'd0;

    always_comb begin
        if (i_cfg.spp == '0) begin
            spp_eff = 3'd1;
        end else if ({1'b0, i_cfg.spp} > 3'(MAX_CHANNELS)) begin
            spp_eff = 3'(MAX_CHANNELS);
        end else begin
            spp_eff = {1'b0, i_cfg.spp};
        end
        row_eff = (i_cfg.row == '0) ? hdp_pkg::ROW_W'(1) : i_cfg.row;
    end

    always_comb begin
        prev = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (ch_sel == 3'(i)) begin
                prev = r_prev[i];
            end
        end
    end

    always_comb begin
        sample = i_cfg.wide ? SAMPLE_BITS'({i_data, r_held}) : SAMPLE_BITS'(i_data);
        res_w  = ((r_col == '0) ? sample : (sample - prev)) ^ SIGN_W;
        res_n  = ((r_col == '0) ? i_data : (i_data - prev[hdp_pkg::BYTE_W-1:0]))
                 ^ hdp_pkg::SIGN8;
        res_w16 = 16'(res_w);
    end

    always_comb begin
        o_q_push        = step;
        o_q_entry.wide  = i_cfg.wide;
        o_q_entry.lo    = i_cfg.wide ? res_w16[7:0] : res_n;
        o_q_entry.hi    = i_cfg.wide ? res_w16[15:8] : '0;
    end

    // channel / column advance
    always_comb begin
        chan_inc = r_chan + 2'd1;
        col_inc  = r_col + hdp_pkg::ROW_W'(1);
        n_chan   = chan_inc;
        n_col    = r_col;
        if ({1'b0, chan_inc} >= spp_eff) begin
            n_chan = '0;
            n_col  = (col_inc >= row_eff) ? '0 : col_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_col   <= '0;
            r_held  <= '0;
            r_phase <= 1'b0;
        end else if (accept) begin
            if (!i_cfg.wide) begin
                r_phase <= 1'b0;
                r_held  <= '0;
            end else if (!r_phase) begin
                r_held  <= i_data;
                r_phase <= 1'b1;
            end else begin
                r_phase <= 1'b0;
            end
            if (step) begin
                r_chan <= n_chan;
                r_col  <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (!i_rst_n) begin
                r_prev[i] <= '0;
            end else if (step && ch_sel == 3'(i)) begin
                r_prev[i] <= sample;
            end
        end
    end

endmodule

### sv/hdp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_queue - short sample queue
// Two-entry FIFO that decouples the predictor from the output sequencer.
// ----------------------------------------------------------------------------
module hdp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hdp_pkg::t_qent  i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output hdp_pkg::t_qent  o_entry
);

    localparam int PTR_W = $clog2(hdp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hdp_pkg::QUEUE_DEPTH + 1);

    hdp_pkg::t_qent     r_mem [hdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_ready = (r_cnt != CNT_W'(hdp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(hdp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(hdp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/hdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_back - output beat sequencer
// Splits queued samples into byte beats and holds them in an output register.
// ----------------------------------------------------------------------------
module hdp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  hdp_pkg::t_qent              i_q_entry,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hdp_pkg::BYTE_W-1:0]  o_data,
    output logic                        o_last
);

    logic                        r_valid;
    logic [hdp_pkg::BYTE_W-1:0]  r_data;
    logic                        r_last;
    logic                        r_beat;   // high byte of a wide sample is next

    logic                        n_valid;
    logic [hdp_pkg::BYTE_W-1:0]  n_data;
    logic                        n_last;
    logic                        n_beat;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_beat  = r_beat;
        o_q_pop = 1'b0;
        if (!r_valid || i_ready) begin
            n_valid = i_q_valid;
            if (i_q_valid) begin
                if (i_q_entry.wide && !r_beat) begin
                    n_data = i_q_entry.lo;
                    n_last = 1'b0;
                    n_beat = 1'b1;
                end else begin
                    n_data  = r_beat ? i_q_entry.hi : i_q_entry.lo;
                    n_last  = 1'b1;
                    n_beat  = 1'b0;
                    o_q_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

### sv/horizontal_delta_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horizontal_delta_predictor_unit - horizontal differencing predictor
// Turns a raw image byte stream into sign-flipped horizontal differences.
// ----------------------------------------------------------------------------
// The unit takes one raw image byte per beat on the slave stream and runs at
// one byte per clock in both directions unless the queue or output stalls.
// Samples are one byte, or two bytes low byte first; channels of a pixel are
// interleaved. Each sample has the same channel's sample of the previous
// pixel in the row subtracted (modulo the sample width), the first pixel of a
// row passes unchanged, and the result has its sign bit inverted. A narrow
// sample yields one output beat with tlast set; a wide sample yields nothing
// on its low byte and two beats (low, then high with tlast) once its high
// byte arrives. The front end predicts in the accept cycle and pushes into a
// two-entry queue; the back end sequences beats into an output register.
// Configuration is written through the cfg channel (always ready); the user
// must write it only while the stream is idle, the block does not enforce it.
// Index 0 wide_samples, 1 samples_per_pixel, 2 row_width.
// ----------------------------------------------------------------------------
module horizontal_delta_predictor_unit #(
    parameter int MAX_CHANNELS = hdp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = hdp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hdp_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hdp_pkg::BYTE_W-1:0]      m_axis_tdata,   // [7:0] out_byte
    output logic                            m_axis_tlast    // last_of_run
);

    logic                             r_wide;
    logic [hdp_pkg::SPP_W-1:0]        r_spp;
    logic [hdp_pkg::ROW_W-1:0]        r_row;
    hdp_pkg::t_cfg                    cfg;

    logic                             q_ready;
    logic                             q_push;
    hdp_pkg::t_qent                   q_in;
    logic                             q_valid;
    logic                             q_pop;
    hdp_pkg::t_qent                   q_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
            r_spp  <= hdp_pkg::SPP_W'(1);
            r_row  <= hdp_pkg::ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hdp_pkg::t_cfg_idx'(i_cfg_index))
                hdp_pkg::CFG_WIDE_SAMPLES:      r_wide <= i_cfg_data[0];
                hdp_pkg::CFG_SAMPLES_PER_PIXEL: r_spp  <= i_cfg_data[hdp_pkg::SPP_W-1:0];
                hdp_pkg::CFG_ROW_WIDTH:         r_row  <= i_cfg_data[hdp_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.wide = r_wide;
        cfg.spp  = r_spp;
        cfg.row  = r_row;
    end

    hdp_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .o_ready   (s_axis_tready),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    hdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    hdp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

### test/horizontal_delta_predictor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horizontal_delta_predictor_unit_tb - self-checking testbench
// Streams raw image bytes through the predictor under several register
// settings and random back pressure. Every output beat is compared with a
// scoreboard that redoes the horizontal differencing and sign flip itself.
// ----------------------------------------------------------------------------
module horizontal_delta_predictor_unit_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 1100;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;     // long output stall
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_CHANNELS  = hdp_pkg::MAX_CHANNELS_DEF;
    localparam logic [15:0] SIGN16 = 16'h8000;

    typedef struct packed {
        logic [hdp_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_beat;

    typedef enum int {
        STYLE_SMOOTH,
        STYLE_NOISE,
        STYLE_EXTREME
    } t_style;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and stream state and
    // queues the beats each accepted byte should produce.
    // ------------------------------------------------------------------------
    class delta_scoreboard;
        logic                       wide;
        logic [hdp_pkg::SPP_W-1:0]  spp;
        logic [hdp_pkg::ROW_W-1:0]  row_w;
        logic [15:0]                last_sample [NUM_CHANNELS];
        logic [1:0]                 chan;
        logic [hdp_pkg::ROW_W-1:0]  column;
        logic [7:0]                 held_lo;
        logic                       lo_pending;
        t_beat                      expected_beats [$];
        int                         errors;
        int                         bytes_taken;
        int                         beats_checked;
        int                         writes;

        function new();
            wide       = 1'b0;
            spp        = 2'd1;
            row_w      = 16'd1;
            chan       = '0;
            column     = '0;
            held_lo    = '0;
            lo_pending = 1'b0;
            foreach (last_sample[i]) last_sample[i] = '0;
            errors = 0; bytes_taken = 0; beats_checked = 0; writes = 0;
        endfunction

        function void write_reg(hdp_pkg::t_cfg_idx idx,
                                logic [hdp_pkg::CFG_DATA_W-1:0] value);
            writes++;
            case (idx)
                hdp_pkg::CFG_WIDE_SAMPLES:      wide  = value[0];
                hdp_pkg::CFG_SAMPLES_PER_PIXEL: spp   = value[hdp_pkg::SPP_W-1:0];
                hdp_pkg::CFG_ROW_WIDTH:         row_w = value[hdp_pkg::ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // difference against the previous pixel of the same channel, then
        // advance channel / column with the clamped limits
        function logic [15:0] predict(logic [15:0] sample, bit is_wide);
            int          slot;
            int          lanes;
            int          row_len;
            logic [15:0] diff;
            slot = (chan < NUM_CHANNELS) ? int'(chan) : 0;
            if (!is_wide) sample[15:8] = '0;
            diff = (column == 0) ? sample : sample - last_sample[slot];
            if (!is_wide) diff[15:8] = '0;
            last_sample[slot] = sample;

            lanes   = (spp == 0) ? 1 : int'(spp);
            if (lanes > NUM_CHANNELS) lanes = NUM_CHANNELS;
            row_len = (row_w == 0) ? 1 : int'(row_w);

            chan = chan + 2'd1;
            if (int'(chan) >= lanes) begin
                chan   = '0;
                column = column + 16'd1;
                if (int'(column) >= row_len) column = '0;
            end
            return is_wide ? (diff ^ SIGN16) : {8'h00, diff[7:0] ^ hdp_pkg::SIGN8};
        endfunction

        function void take_byte(logic [hdp_pkg::BYTE_W-1:0] b);
            logic [15:0] r;
            bytes_taken++;
            if (!wide) begin
                // narrow mode drops any half-finished wide sample
                lo_pending = 1'b0;
                held_lo    = '0;
                r = predict({8'h00, b}, 1'b0);
                expected_beats.push_back('{data: r[7:0], last: 1'b1});
            end else if (!lo_pending) begin
                held_lo    = b;
                lo_pending = 1'b1;
            end else begin
                lo_pending = 1'b0;
                r = predict({b, held_lo}, 1'b1);
                expected_beats.push_back('{data: r[7:0],  last: 1'b0});
                expected_beats.push_back('{data: r[15:8], last: 1'b1});
            end
        endfunction

        function void check_beat(logic [hdp_pkg::BYTE_W-1:0] data, logic last);
            t_beat exp_beat;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                $error("unexpected output beat: out_byte 0x%02h last_of_run %0b", data, last);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (data !== exp_beat.data) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", exp_beat.data, data);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $error("last_of_run: expected %0b, got %0b", exp_beat.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; the bench-driven inputs are known from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [hdp_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [hdp_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [hdp_pkg::BYTE_W-1:0]     s_axis_tdata  = '0;     // [7:0] data_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [hdp_pkg::BYTE_W-1:0]     m_axis_tdata;           // [7:0] out_byte
    logic                           m_axis_tlast;           // last_of_run

    delta_scoreboard sb = new();

    // idle rates in percent, set by the stimulus thread
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int holds_requested = 0;
    int cycle_count     = 0;

    // stimulus-side view of the current settings, used to shape images
    logic        cur_wide = 1'b0;
    int          cur_lanes = 1;
    int          cur_row   = 1;
    logic [15:0] gen_last [NUM_CHANNELS];

    horizontal_delta_predictor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitors: everything is sampled at the rising edge, before this edge's
    // nonblocking updates land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.write_reg(hdp_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.take_byte(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random ready, plus a long hold-off whenever one is requested.
    // The hold is counted here so the sender can keep pushing meanwhile.
    initial begin : out_ready
        int left;
        int served;
        left   = 0;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (served < holds_requested) begin
                served++;
                left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (left > 0) begin
                left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One input beat; random idle cycles ahead of it. valid stays up after
    // the accepting edge so back-to-back beats need no extra NBA.
    task automatic send_byte(input logic [hdp_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic cfg_write(input hdp_pkg::t_cfg_idx idx,
                             input logic [hdp_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Sender pauses until every expected beat is out, then lets the pipe
    // settle (a held low byte gives no beat to wait on). The first edge lets
    // the monitor log the last accepted beat before the count is trusted.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the selected registers while the stream is idle. Upper data bits
    // are sometimes filled with junk; the block keeps only the field bits.
    task automatic reconfigure(input bit do_wide, input logic w,
                               input bit do_spp, input logic [1:0] s,
                               input bit do_row, input logic [15:0] r);
        logic [hdp_pkg::CFG_DATA_W-1:0] value;
        wait_for_drain();
        if (do_wide) begin
            value = ($urandom_range(3) == 0) ? {15'($urandom), w} : 16'(w);
            cfg_write(hdp_pkg::CFG_WIDE_SAMPLES, value);
            cur_wide = w;
        end
        if (do_spp) begin
            value = ($urandom_range(3) == 0) ? {14'($urandom), s} : 16'(s);
            cfg_write(hdp_pkg::CFG_SAMPLES_PER_PIXEL, value);
            cur_lanes = (s == 0) ? 1 : int'(s);
        end
        if (do_row) begin
            cfg_write(hdp_pkg::CFG_ROW_WIDTH, r);
            cur_row = (r == 0) ? 1 : int'(r);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] make_sample(t_style style, logic [15:0] prev, logic w);
        logic [15:0] s;
        case (style)
            STYLE_SMOOTH:
                s = 16'(int'(prev) + int'($urandom_range(0, 16)) - 8);
            STYLE_NOISE:
                s = 16'($urandom);
            default:
                case ($urandom_range(3))
                    0: s = 16'h0000;
                    1: s = 16'hffff;
                    2: s = w ? 16'h8000 : 16'h0080;
                    default: s = w ? 16'h7fff : 16'h007f;
                endcase
        endcase
        if (!w) s[15:8] = '0;
        return s;
    endfunction

    // Whole pixels, channels interleaved, wide samples low byte first.
    // Returns the number of bytes sent.
    task automatic send_samples(input int count, input t_style style, output int sent);
        int          ch;
        logic [15:0] s;
        sent = 0;
        ch   = 0;
        for (int n = 0; n < count; n++) begin
            s = make_sample(style, gen_last[ch], cur_wide);
            gen_last[ch] = s;
            send_byte(s[7:0]);
            sent++;
            if (cur_wide) begin
                send_byte(s[15:8]);
                sent++;
            end
            ch = (ch + 1 >= cur_lanes) ? 0 : ch + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          rand_bytes;
        int          phases;
        int          sent;
        int          count;
        bit          hold_done;
        logic        w;
        logic [1:0]  s;
        logic [15:0] r;
        int          pick;

        rand_bytes = 0;
        phases     = 0;
        hold_done  = 1'b0;
        foreach (gen_last[i]) gen_last[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // reset settings: one channel, one pixel per row, so every byte is a
        // row start and only gets its sign bit flipped
        send_byte(8'h00); send_byte(8'hff); send_byte(8'h80); send_byte(8'h7f);

        // four-pixel rows: wrap-around subtraction and the row restart
        reconfigure(1'b0, 1'b0, 1'b1, 2'd1, 1'b1, 16'd4);
        send_byte(8'h10); send_byte(8'h05); send_byte(8'hff); send_byte(8'h00);

        // zero channel count and zero row width both behave as one
        reconfigure(1'b0, 1'b0, 1'b1, 2'd0, 1'b1, 16'd0);
        send_byte(8'h33); send_byte(8'h44);

        // three interleaved channels, two pixels per row
        reconfigure(1'b0, 1'b0, 1'b1, 2'd3, 1'b1, 16'd2);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
        send_byte(8'h00); send_byte(8'hff); send_byte(8'h80);

        // wide samples, then a dangling low byte
        reconfigure(1'b1, 1'b1, 1'b1, 2'd1, 1'b1, 16'd2);
        send_byte(8'h00); send_byte(8'h80); send_byte(8'hff); send_byte(8'h7f);
        send_byte(8'h34);

        // back to narrow: the held low byte is dropped
        reconfigure(1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0);
        send_byte(8'h5a);

        // ---- random part ----
        while (rand_bytes < RANDOM_BYTES) begin
            if (rand_bytes < RANDOM_BYTES / 3) begin
                tx_idle_pct = 29; rx_idle_pct = 85;
            end else if (rand_bytes < 2 * RANDOM_BYTES / 3) begin
                tx_idle_pct = 85; rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;  rx_idle_pct = 0;
            end
            phases++;

            if (!hold_done && rand_bytes >= 2 * RANDOM_BYTES / 3) begin
                // long output stall with the sender still pushing: the queue
                // fills and the input side has to back off
                hold_done = 1'b1;
                reconfigure(1'b1, 1'b0, 1'b1, 2'd1, 1'b1, 16'd5);
                holds_requested++;
                send_samples(60, STYLE_NOISE, sent);
                rand_bytes += sent;
                continue;
            end

            w = 1'($urandom_range(1));
            s = 2'($urandom_range(3));
            pick = $urandom_range(9);
            if (pick == 0)      r = 16'd0;
            else if (pick == 1) r = 16'hffff;
            else if (pick == 2) r = 16'($urandom);
            else                r = 16'($urandom_range(1, 6));
            reconfigure($urandom_range(3) != 0, w, $urandom_range(3) != 0, s,
                        $urandom_range(3) != 0, r);

            if ($urandom_range(4) == 0) begin
                // raw noise, any byte count, odd ones leave a byte held
                count = $urandom_range(1, 25);
                for (int n = 0; n < count; n++) send_byte(8'($urandom));
                rand_bytes += count;
            end else begin
                // whole rows of an image where the row is short enough
                if (cur_row <= 6)
                    count = cur_lanes * cur_row * $urandom_range(1, 3);
                else
                    count = $urandom_range(10, 40);
                pick = $urandom_range(9);
                send_samples(count,
                             (pick < 6) ? STYLE_SMOOTH :
                             (pick < 9) ? STYLE_NOISE : STYLE_EXTREME, sent);
                rand_bytes += sent;
            end
        end

        // ---- wind down ----
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d input bytes, %0d output beats, %0d register writes over %0d phases,",
                 sb.bytes_taken, sb.beats_checked, sb.writes, phases);
        $display("with one %0d-cycle output stall and mixed idle rates on both sides.",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d beats never seen", sb.errors, sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
